[hdl/mfq_pkg.sv]
`default_nettype none

package mfq_pkg;

    // Default table geometry
    localparam int SLOTS_DEF  = 32;
    localparam int LEVELS_DEF = 4;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int SLOT_W    = 5;
    localparam int OC_W      = 2;
    localparam int PID_W     = 32;
    localparam int CODE_W    = 3;
    localparam int LVL_OUT_W = 3;
    localparam int QW        = 24;

    // Quantum registers
    localparam int QUANTA = 4;
    localparam int CFG_IW = $clog2(QUANTA);
    localparam logic [QUANTA-1:0][QW-1:0] QUANTUM_RST = {
        24'd80000, 24'd40000, 24'd20000, 24'd10000
    };

    typedef enum logic [REQ_W-1:0] {
        REQ_ADMIT,
        REQ_PICK,
        REQ_OUTCOME,
        REQ_UNBLOCK
    } t_req_type;

    typedef enum logic [OC_W-1:0] {
        OC_TERM,
        OC_FULL,
        OC_BLOCK,
        OC_PREEMPT
    } t_outcome;

    typedef enum logic [CODE_W-1:0] {
        RES_OK,
        RES_FULL,
        RES_NONE,
        RES_NOT_USED,
        RES_INVALID
    } t_result;

    typedef logic [QUANTA-1:0][QW-1:0] t_quanta;

    typedef struct packed {
        t_req_type        req_type;
        logic [SLOT_W-1:0] slot;
        t_outcome         outcome;
        logic [PID_W-1:0] pid;
    } t_req;

    typedef struct packed {
        t_result              code;
        logic [SLOT_W-1:0]    slot;
        logic [PID_W-1:0]     pid;
        logic [QW-1:0]        quantum;
        logic [LVL_OUT_W-1:0] level;
    } t_rsp;

endpackage

`default_nettype wire

[hdl/multilevel_feedback_queue_scheduler_top.sv]
// The request is registered in r_req, the engine answers from it, and the answer is
// registered in r_rsp with the strobe o_valid, from which the result is taken.
// Throughput: one request per cycle; busy never rises, every cycle can take a transfer.
// Each request is decoded, applied to the slot table and answered in one registered pass.
// Reset (synchronous, active low) frees all slots, empties all lists, reloads quanta.
// Results appear for one cycle on o_valid; the receiver cannot stall them.
`default_nettype none

module multilevel_feedback_queue_scheduler_top
    import mfq_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [SLOT_W-1:0]    i_slot,
    input  wire logic [OC_W-1:0]      i_outcome,
    input  wire logic [PID_W-1:0]     i_new_pid,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IW-1:0]    i_cfg_idx,
    input  wire logic [QW-1:0]        i_cfg_data,
    output logic                      o_valid,
    output logic [CODE_W-1:0]         o_result_code,
    output logic [SLOT_W-1:0]         o_out_slot,
    output logic [PID_W-1:0]          o_out_pid,
    output logic [QW-1:0]             o_out_quantum,
    output logic [LVL_OUT_W-1:0]      o_out_level
);

    logic    r_req_vld;
    t_req    r_req;
    logic    r_out_vld;
    t_rsp    r_rsp;
    t_rsp    w_rsp;
    t_quanta w_quanta;

    assign busy = 1'b0;

    // Capture each request transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req.req_type <= t_req_type'(i_req_type);
            r_req.slot     <= i_slot;
            r_req.outcome  <= t_outcome'(i_outcome);
            r_req.pid      <= i_new_pid;
        end
    end

    mfq_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (i_cfg_we),
        .i_idx    (i_cfg_idx),
        .i_data   (i_cfg_data),
        .o_quanta (w_quanta)
    );

    mfq_engine #(
        .SLOTS  (SLOTS),
        .LEVELS (LEVELS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_req_vld),
        .i_req    (r_req),
        .i_quanta (w_quanta),
        .o_rsp    (w_rsp)
    );

    // Register the result and strobe it for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result_code = r_rsp.code;
    assign o_out_slot    = r_rsp.slot;
    assign o_out_pid     = r_rsp.pid;
    assign o_out_quantum = r_rsp.quantum;
    assign o_out_level   = r_rsp.level;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld |=> o_valid)
        else $error("request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_req_vld |=> !o_valid)
        else $error("result without a request");

endmodule

`default_nettype wire

[hdl/mfq_cfg.sv]
`default_nettype none

module mfq_cfg
    import mfq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [CFG_IW-1:0] i_idx,
    input  wire logic [QW-1:0]     i_data,
    output t_quanta                o_quanta
);

    t_quanta r_quanta;

    // Load reset quanta, then take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quanta <= QUANTUM_RST;
        end else if (i_we) begin
            r_quanta[i_idx] <= i_data;
        end
    end

    assign o_quanta = r_quanta;

endmodule

`default_nettype wire

[hdl/mfq_engine.sv]
`default_nettype none

module mfq_engine
    import mfq_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_vld,
    input  t_req      i_req,
    input  t_quanta   i_quanta,
    output t_rsp      o_rsp
);

    localparam int SW    = $clog2(SLOTS);
    localparam int PW    = $clog2(SLOTS + 1);
    localparam int LISTS = LEVELS + 1;
    localparam int LW    = $clog2(LISTS);
    localparam int QIW   = $clog2(QUANTA);
    localparam logic [PW-1:0] NIL     = PW'(SLOTS);
    localparam logic [LW-1:0] BLOCKED = LW'(LEVELS);

    // Slot table and list state
    logic              r_in_use [SLOTS];
    logic [LW-1:0]     r_level  [SLOTS];
    logic [PID_W-1:0]  r_pid    [SLOTS];
    logic [PW-1:0]     r_next   [SLOTS];
    logic [PW-1:0]     r_prev   [SLOTS];
    logic [PW-1:0]     r_head   [LISTS];
    logic [PW-1:0]     r_tail   [LISTS];

    logic [SW-1:0]    w_s;
    logic             w_s_ok;
    logic             w_s_used;
    logic [LW-1:0]    w_lvl_s;
    logic [PW-1:0]    w_p;
    logic [PW-1:0]    w_n;
    logic [PW-1:0]    w_t;
    logic [SW-1:0]    w_rd;
    logic [PID_W-1:0] w_rd_pid;
    logic             w_free_any;
    logic [SW-1:0]    w_free_idx;
    logic             w_pick_any;
    logic [LW-1:0]    w_pick_lvl;
    logic [SW-1:0]    w_pick_slot;
    logic [QIW-1:0]   w_qi;
    logic             w_unlink;
    logic             w_append;
    logic [SW-1:0]    w_app_slot;
    logic [LW-1:0]    w_app_list;
    logic             w_set_use;
    logic             w_clr_use;
    logic             w_ht_ok;

    // Address the requested slot
    assign w_s      = SW'(i_req.slot);
    assign w_s_ok   = (32'(i_req.slot) < SLOTS);
    assign w_s_used = w_s_ok && r_in_use[w_s];
    assign w_lvl_s  = r_level[w_s];
    assign w_p      = r_prev[w_s];
    assign w_n      = r_next[w_s];
    assign w_t      = r_tail[w_app_list];

    // Find the lowest free slot
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_free_any = 1'b1;
                w_free_idx = SW'(i);
            end
        end
    end

    // Find the highest-priority non-empty ready list
    always_comb begin
        w_pick_any = 1'b0;
        w_pick_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_head[l] != NIL) begin
                w_pick_any = 1'b1;
                w_pick_lvl = LW'(l);
            end
        end
    end

    assign w_pick_slot = r_head[w_pick_lvl][SW-1:0];
    assign w_qi = (32'(w_pick_lvl) < QUANTA) ? QIW'(w_pick_lvl) : QIW'(QUANTA - 1);

    // Single pid read port
    assign w_rd     = (i_req.req_type == REQ_PICK) ? w_pick_slot : w_s;
    assign w_rd_pid = r_pid[w_rd];

    // Decide the move and build the response
    always_comb begin
        w_unlink   = 1'b0;
        w_append   = 1'b0;
        w_app_slot = w_s;
        w_app_list = '0;
        w_set_use  = 1'b0;
        w_clr_use  = 1'b0;
        o_rsp      = '0;
        case (i_req.req_type)
            REQ_ADMIT: begin
                if (w_free_any) begin
                    w_set_use   = 1'b1;
                    w_append    = 1'b1;
                    w_app_slot  = w_free_idx;
                    o_rsp.code  = RES_OK;
                    o_rsp.slot  = SLOT_W'(w_free_idx);
                    o_rsp.pid   = i_req.pid;
                end else begin
                    o_rsp.code  = RES_FULL;
                end
            end
            REQ_PICK: begin
                if (w_pick_any) begin
                    o_rsp.code    = RES_OK;
                    o_rsp.slot    = SLOT_W'(w_pick_slot);
                    o_rsp.pid     = w_rd_pid;
                    o_rsp.quantum = i_quanta[w_qi];
                    o_rsp.level   = LVL_OUT_W'(w_pick_lvl);
                end else begin
                    o_rsp.code    = RES_NONE;
                end
            end
            REQ_OUTCOME, REQ_UNBLOCK: begin
                o_rsp.slot = i_req.slot;
                if (!w_s_used) begin
                    o_rsp.code  = RES_NOT_USED;
                    o_rsp.level = LVL_OUT_W'(LEVELS + 1);
                end else begin
                    o_rsp.pid   = w_rd_pid;
                    o_rsp.code  = RES_OK;
                    o_rsp.level = LVL_OUT_W'(w_lvl_s);
                    if (i_req.req_type == REQ_OUTCOME) begin
                        if (i_req.outcome == OC_TERM) begin
                            w_unlink    = 1'b1;
                            w_clr_use   = 1'b1;
                            o_rsp.level = LVL_OUT_W'(LEVELS + 1);
                        end else if (w_lvl_s == BLOCKED) begin
                            o_rsp.code  = RES_INVALID;
                        end else if (i_req.outcome == OC_BLOCK) begin
                            w_unlink    = 1'b1;
                            w_append    = 1'b1;
                            w_app_list  = BLOCKED;
                            o_rsp.level = LVL_OUT_W'(BLOCKED);
                        end else if (32'(w_lvl_s) + 1 < LEVELS) begin
                            // demote one level
                            w_unlink    = 1'b1;
                            w_append    = 1'b1;
                            w_app_list  = w_lvl_s + LW'(1);
                            o_rsp.level = LVL_OUT_W'(w_lvl_s + LW'(1));
                        end
                    end else begin
                        if (w_lvl_s != BLOCKED) begin
                            o_rsp.code  = RES_INVALID;
                        end else begin
                            w_unlink    = 1'b1;
                            w_append    = 1'b1;
                            o_rsp.level = '0;
                        end
                    end
                end
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

    // Hold the slot-in-use map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_in_use[i] <= 1'b0;
            end
        end else if (i_vld) begin
            if (w_set_use) begin
                r_in_use[w_free_idx] <= 1'b1;
            end
            if (w_clr_use) begin
                r_in_use[w_s] <= 1'b0;
            end
        end
    end

    // Update slot payload and links; unlink and append touch distinct slots
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            if (w_set_use) begin
                r_pid[w_free_idx] <= i_req.pid;
            end
            if (w_unlink) begin
                if (w_p != NIL) begin
                    r_next[w_p[SW-1:0]] <= w_n;
                end
                if (w_n != NIL) begin
                    r_prev[w_n[SW-1:0]] <= w_p;
                end
            end
            if (w_append) begin
                r_level[w_app_slot] <= w_app_list;
                r_prev[w_app_slot]  <= w_t;
                r_next[w_app_slot]  <= NIL;
                if (w_t != NIL) begin
                    r_next[w_t[SW-1:0]] <= PW'(w_app_slot);
                end
            end
        end
    end

    // Update list heads and tails; source and target lists always differ
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LISTS; l++) begin
                r_head[l] <= NIL;
                r_tail[l] <= NIL;
            end
        end else if (i_vld) begin
            if (w_unlink) begin
                if (w_p == NIL) begin
                    r_head[w_lvl_s] <= w_n;
                end
                if (w_n == NIL) begin
                    r_tail[w_lvl_s] <= w_p;
                end
            end
            if (w_append) begin
                if (w_t == NIL) begin
                    r_head[w_app_list] <= PW'(w_app_slot);
                end
                r_tail[w_app_list] <= PW'(w_app_slot);
            end
        end
    end

    // A list is empty at its head exactly when it is empty at its tail
    always_comb begin
        w_ht_ok = 1'b1;
        for (int l = 0; l < LISTS; l++) begin
            if ((r_head[l] == NIL) != (r_tail[l] == NIL)) begin
                w_ht_ok = 1'b0;
            end
        end
    end

    a_head_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ht_ok)
        else $error("list head and tail disagree on empty");

    a_pick_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pick_any |-> r_in_use[w_pick_slot])
        else $error("ready list head points at a free slot");

endmodule

`default_nettype wire
